@@ sv/assert_macros.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/cpct_pkg.sv @@
// Package with the shared types and constants of the pair contact tracker.
`default_nettype none

package cpct_pkg;

   // Field widths of one request.
   localparam int POS_W    = 24;
   localparam int SIZE_W   = 16;

   // Scaled sizes and the derived quantities.
   localparam int SIZE_SCALE = 100;
   localparam int SCALED_W   = 23;   // 65535 * 100 fits in 23 bits
   localparam int SUM_W      = 24;   // sum of two scaled sizes
   localparam int DIFF_W     = 25;   // difference of two positions
   localparam int ABS2_W     = 26;   // doubled absolute difference
   localparam int DELTA_W    = 27;   // doubled circle center difference
   localparam int PROD_W     = 54;   // square of a doubled center difference

   // Shape kinds.
   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

   // Contact events.
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_STAY  = 2'd2,
      EV_EXIT  = 2'd3
   } event_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic capture;
      logic scale;
      logic sums;
      logic mul_x;
      logic mul_y;
      logic mul_r;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

@@ sv/cpct_req_if.sv @@
// Request channel of the pair contact tracker.
`default_nettype none

interface cpct_req_if #(
   parameter int ID_BITS = 6
);
   logic                               valid;
   logic                               ready;
   logic        [ID_BITS-1:0]          left_id;
   logic        [ID_BITS-1:0]          right_id;
   logic signed [cpct_pkg::POS_W-1:0]  left_x;
   logic signed [cpct_pkg::POS_W-1:0]  left_y;
   logic        [cpct_pkg::SIZE_W-1:0] left_w;
   logic        [cpct_pkg::SIZE_W-1:0] left_h;
   logic                               left_kind;
   logic signed [cpct_pkg::POS_W-1:0]  right_x;
   logic signed [cpct_pkg::POS_W-1:0]  right_y;
   logic        [cpct_pkg::SIZE_W-1:0] right_w;
   logic        [cpct_pkg::SIZE_W-1:0] right_h;
   logic                               right_kind;

   modport source (
      output valid, left_id, right_id, left_x, left_y, left_w, left_h, left_kind,
             right_x, right_y, right_w, right_h, right_kind,
      input  ready
   );

   modport sink (
      input  valid, left_id, right_id, left_x, left_y, left_w, left_h, left_kind,
             right_x, right_y, right_w, right_h, right_kind,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/cpct_rsp_if.sv @@
// Result channel of the pair contact tracker.
`default_nettype none

interface cpct_rsp_if;
   logic                valid;
   logic                ready;
   cpct_pkg::event_type contact_event;
   logic                overlapping;

   modport source (
      output valid, contact_event, overlapping,
      input  ready
   );

   modport sink (
      input  valid, contact_event, overlapping,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/cpct_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cpct_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/cpct_ctrl.sv @@
// Controller state machine of the pair contact tracker.
`default_nettype none

module cpct_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cpct_pkg::sts_type sts,
   output cpct_pkg::cmd_type      cmd
);

`include "assert_macros.svh"

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_SCALE = 8'b00000100,
      S_SUMS  = 8'b00001000,
      S_MULX  = 8'b00010000,
      S_MULY  = 8'b00100000,
      S_MULR  = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_SUMS;
         end
         S_SUMS: begin
            cmd.sums = 1'b1;
            state_in = S_MULX;
         end
         S_MULX: begin
            cmd.mul_x = 1'b1;
            state_in  = S_MULY;
         end
         S_MULY: begin
            cmd.mul_y = 1'b1;
            state_in  = S_MULR;
         end
         S_MULR: begin
            cmd.mul_r = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // Hold the result until the output register can take it.
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the table clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `ASSERT_IMPLIES(a_finish_has_room, clock, reset, cmd.finish, sts.rsp_free,
      "result loaded while the output register is still full")
   `ASSERT_NEXT(a_single_capture, clock, reset, cmd.capture, !req_ready,
      "second request accepted while one is in flight")
   `ASSERT_IMPLIES(a_no_accept_in_clear, clock, reset, cmd.clear, !req_ready,
      "request accepted during the table clearing pass")

endmodule

`default_nettype wire

@@ sv/cpct_dp.sv @@
// Datapath of the pair contact tracker: overlap arithmetic, touching table, result register.
`default_nettype none

module cpct_dp #(
   parameter int ID_BITS = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   cpct_req_if.sink               req,
   cpct_rsp_if.source             rsp,
   input  wire cpct_pkg::cmd_type cmd,
   output cpct_pkg::sts_type      sts
);

`include "assert_macros.svh"

   localparam int ADDR_BITS = 2 * ID_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;

   // Captured request.
   logic        [ID_BITS-1:0]          lid_ff, rid_ff;
   logic signed [cpct_pkg::POS_W-1:0]  lx_ff, ly_ff, rx_ff, ry_ff;
   logic        [cpct_pkg::SIZE_W-1:0] lw_ff, lh_ff, rw_ff, rh_ff;
   logic                               lk_ff, rk_ff;

   // Intermediate values.
   logic                                 was_ff;
   logic        [cpct_pkg::SCALED_W-1:0] lws_ff, lhs_ff, rws_ff, rhs_ff;
   logic signed [cpct_pkg::DIFF_W-1:0]   ddx_ff, ddy_ff;
   logic        [cpct_pkg::SUM_W-1:0]    sumw_ff, sumh_ff;
   logic signed [cpct_pkg::DELTA_W-1:0]  dx_ff, dy_ff;
   logic        [cpct_pkg::ABS2_W-1:0]   adx2_ff, ady2_ff;
   logic                                 rect_ff;
   logic        [cpct_pkg::PROD_W-1:0]   prod_ff, acc_ff;

   // Clearing pass and result register.
   logic [ADDR_BITS-1:0] clr_cnt_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   cpct_pkg::event_type  rsp_event_ff, rsp_event_in;
   logic                 rsp_ovl_ff, rsp_ovl_in;

   // Table port signals.
   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_waddr;
   logic                 ram_wdata;
   logic [ADDR_BITS-1:0] ram_raddr;
   logic                 ram_rdata;

   // Shared squarer.
   logic signed [cpct_pkg::DELTA_W-1:0] mul_a;
   logic signed [cpct_pkg::PROD_W-1:0]  square;

   // Overlap results.
   logic circ_hit;
   logic now_hit;

   // Capture the request fields when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lid_ff <= req.left_id;
         rid_ff <= req.right_id;
         lx_ff  <= req.left_x;
         ly_ff  <= req.left_y;
         lw_ff  <= req.left_w;
         lh_ff  <= req.left_h;
         lk_ff  <= req.left_kind;
         rx_ff  <= req.right_x;
         ry_ff  <= req.right_y;
         rw_ff  <= req.right_w;
         rh_ff  <= req.right_h;
         rk_ff  <= req.right_kind;
      end
   end

   // Scale the sizes by 100, form the position differences, latch the table bit.
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         was_ff <= ram_rdata;
         lws_ff <= cpct_pkg::SCALED_W'(lw_ff) * cpct_pkg::SCALED_W'(cpct_pkg::SIZE_SCALE);
         lhs_ff <= cpct_pkg::SCALED_W'(lh_ff) * cpct_pkg::SCALED_W'(cpct_pkg::SIZE_SCALE);
         rws_ff <= cpct_pkg::SCALED_W'(rw_ff) * cpct_pkg::SCALED_W'(cpct_pkg::SIZE_SCALE);
         rhs_ff <= cpct_pkg::SCALED_W'(rh_ff) * cpct_pkg::SCALED_W'(cpct_pkg::SIZE_SCALE);
         ddx_ff <= cpct_pkg::DIFF_W'(lx_ff) - cpct_pkg::DIFF_W'(rx_ff);
         ddy_ff <= cpct_pkg::DIFF_W'(ly_ff) - cpct_pkg::DIFF_W'(ry_ff);
      end
   end

   // Everything works in doubled units so that halving never rounds.
   always_ff @(posedge clock) begin
      if (cmd.sums) begin
         sumw_ff <= cpct_pkg::SUM_W'(lws_ff) + cpct_pkg::SUM_W'(rws_ff);
         sumh_ff <= cpct_pkg::SUM_W'(lhs_ff) + cpct_pkg::SUM_W'(rhs_ff);
         dx_ff   <= (cpct_pkg::DELTA_W'(ddx_ff) <<< 1)
                    + cpct_pkg::DELTA_W'(signed'({1'b0, lws_ff}))
                    - cpct_pkg::DELTA_W'(signed'({1'b0, rws_ff}));
         dy_ff   <= (cpct_pkg::DELTA_W'(ddy_ff) <<< 1)
                    + cpct_pkg::DELTA_W'(signed'({1'b0, lhs_ff}))
                    - cpct_pkg::DELTA_W'(signed'({1'b0, rhs_ff}));
         adx2_ff <= {(ddx_ff[cpct_pkg::DIFF_W-1] ? unsigned'(-ddx_ff) : unsigned'(ddx_ff)),
                     1'b0};
         ady2_ff <= {(ddy_ff[cpct_pkg::DIFF_W-1] ? unsigned'(-ddy_ff) : unsigned'(ddy_ff)),
                     1'b0};
      end
   end

   // Rectangle test: strict on both axes.
   always_ff @(posedge clock) begin
      if (cmd.mul_x) begin
         rect_ff <= (adx2_ff < cpct_pkg::ABS2_W'(sumw_ff))
                 && (ady2_ff < cpct_pkg::ABS2_W'(sumh_ff));
      end
   end

   // One squarer serves dx, dy and the radius sum in turn.
   always_comb begin
      if (cmd.mul_x) begin
         mul_a = dx_ff;
      end else if (cmd.mul_y) begin
         mul_a = dy_ff;
      end else begin
         mul_a = cpct_pkg::DELTA_W'(signed'({1'b0, sumw_ff}));
      end
   end

   assign square = cpct_pkg::PROD_W'(mul_a) * cpct_pkg::PROD_W'(mul_a);

   // Product register and the running sum of squares.
   always_ff @(posedge clock) begin
      if (cmd.mul_x || cmd.mul_y || cmd.mul_r) begin
         prod_ff <= unsigned'(square);
      end
      if (cmd.mul_y) begin
         acc_ff <= prod_ff;
      end else if (cmd.mul_r) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // Circle test and the overlap for this pair of kinds.
   assign circ_hit = (acc_ff <= prod_ff);

   always_comb begin
      if ((lk_ff == cpct_pkg::KIND_RECT) && (rk_ff == cpct_pkg::KIND_RECT)) begin
         now_hit = rect_ff;
      end else if ((lk_ff == cpct_pkg::KIND_CIRCLE) && (rk_ff == cpct_pkg::KIND_CIRCLE)) begin
         now_hit = circ_hit;
      end else begin
         now_hit = 1'b0;
      end
   end

   // Touching table: cleared after reset, read on capture, written on finish.
   assign ram_we    = cmd.clear || cmd.finish;
   assign ram_waddr = cmd.clear ? clr_cnt_ff : {lid_ff, rid_ff};
   assign ram_wdata = cmd.clear ? 1'b0 : now_hit;
   assign ram_raddr = {req.left_id, req.right_id};

   cpct_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Clearing pass address counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_BITS'(1);
      end
   end

   // Contact event from the old and new touching state.
   always_comb begin
      rsp_event_in = rsp_event_ff;
      rsp_ovl_in   = rsp_ovl_ff;
      if (cmd.finish) begin
         rsp_ovl_in = now_hit;
         if (now_hit) begin
            rsp_event_in = was_ff ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER;
         end else begin
            rsp_event_in = was_ff ? cpct_pkg::EV_EXIT : cpct_pkg::EV_NONE;
         end
      end
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff <= rsp_event_in;
      rsp_ovl_ff   <= rsp_ovl_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.contact_event = rsp_event_ff;
   assign rsp.overlapping   = rsp_ovl_ff;

   assign sts.clear_last = (clr_cnt_ff == {ADDR_BITS{1'b1}});
   assign sts.rsp_free   = !rsp_valid_ff || rsp.ready;

   `ASSERT_NEXT(a_finish_loads, clock, reset, cmd.finish, rsp.valid,
      "finished request did not reach the output register")
   `ASSERT_NEXT(a_mixed_no_overlap, clock, reset, cmd.finish && (lk_ff != rk_ff),
      !rsp.overlapping, "mixed shape pair reported as overlapping")
   `ASSERT_NEXT(a_result_held, clock, reset, rsp.valid && !rsp.ready, rsp.valid,
      "pending result dropped before it was taken")

endmodule

`default_nettype wire

@@ sv/collider_pair_contact_tracker_unit.sv @@
// Top level of the collider pair contact tracker.
//
// Each request carries an ordered pair of collider ids with position, unscaled
// size and shape kind for both colliders; the unit scales sizes by 100, tests
// rectangle or circle overlap exactly (a mixed pair never overlaps) and
// answers with one result holding the enter, stay, exit or none event and the
// current overlap bit, while updating a touching bit per ordered pair. Each
// request passes through the scale, sums, mul_x, mul_y, mul_r and done states,
// done waiting while the output register is full: a single shared squarer
// forms the two center-distance squares and the radius-sum square one after
// the other; the touching table is a memory with a registered read. A result
// waits in an output register, so the next request is taken while it is still
// pending. After reset the unit clears all 2^(2*ID_BITS) table entries (4096 at
// the default), one per cycle, and accepts no request until that pass is done.
`default_nettype none

module collider_pair_contact_tracker_unit #(
   parameter int ID_BITS = 6
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cpct_req_if.sink   req,
   cpct_rsp_if.source rsp
);

   cpct_pkg::cmd_type cmd;
   cpct_pkg::sts_type sts;
   logic              req_ready;

   // Sequencing of the clearing pass and of each request.
   cpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req.ready = req_ready;

   // Overlap arithmetic, touching table and result register.
   cpct_dp #(
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

`default_nettype wire
